// ===== src/ccc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg: calendar clock counter package
// Item types, operation codes and calendar constants shared by all modules.
// ----------------------------------------------------------------------------
package ccc_pkg;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_LOAD_DATE = 2'd1,
    OP_LOAD_TIME = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hours;
    logic [5:0]  load_minutes;
    logic [5:0]  load_seconds;
  } in_item_t;

  typedef struct packed {
    logic [13:0] year_now;
    logic [3:0]  month_now;
    logic [4:0]  day_now;
    logic [4:0]  hours_now;
    logic [5:0]  minutes_now;
    logic [5:0]  seconds_now;
    logic        second_pulse;
    logic        new_day_pulse;
  } out_item_t;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [3:0]  MONTH_MIN  = 4'd1;
  localparam logic [4:0]  DAY_MIN    = 5'd1;
  localparam logic [4:0]  HOURS_MAX  = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;

  // non-leap month lengths, out-of-range months read as 31
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/ccc_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_in_reg: input register stage
// Holds one accepted input transaction until the core consumes it.
// ----------------------------------------------------------------------------
module ccc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ccc_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_take,
  output ccc_pkg::in_item_t q_data
);

  assign in_ready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_data <= in_data;
    end
  end

endmodule

// ===== src/ccc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_core: clock and calendar state
// Prescaler, time and date registers with rollover and load logic.
// ----------------------------------------------------------------------------
module ccc_core #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fast_mode,
  input  logic               fire,
  input  ccc_pkg::in_item_t  item,
  output ccc_pkg::out_item_t result
);

  localparam int TCW = $clog2(TICKS_PER_SECOND);
  localparam logic [TCW-1:0] TICK_LAST = TCW'(TICKS_PER_SECOND - 1);

  logic [TCW-1:0] tick_count, tick_count_next;
  logic [5:0]     seconds_reg, seconds_next;
  logic [5:0]     minutes_reg, minutes_next;
  logic [4:0]     hours_reg, hours_next;
  logic [4:0]     day_reg, day_next;
  logic [3:0]     month_reg, month_next;
  logic [13:0]    year_reg, year_next;
  logic           sec_p, day_p;

  always_comb begin
    tick_count_next = tick_count;
    seconds_next    = seconds_reg;
    minutes_next    = minutes_reg;
    hours_next      = hours_reg;
    day_next        = day_reg;
    month_next      = month_reg;
    year_next       = year_reg;
    sec_p           = 1'b0;
    day_p           = 1'b0;
    case (item.op)
      ccc_pkg::OP_TICK: begin
        if (fast_mode || tick_count >= TICK_LAST) begin
          tick_count_next = '0;
          sec_p = 1'b1;
          if (seconds_reg >= ccc_pkg::MINSEC_MAX) begin
            seconds_next = '0;
            if (minutes_reg >= ccc_pkg::MINSEC_MAX) begin
              minutes_next = '0;
              if (hours_reg >= ccc_pkg::HOURS_MAX) begin
                hours_next = '0;
                day_p = 1'b1;
                if (day_reg >= ccc_pkg::month_days(month_reg)) begin
                  day_next = ccc_pkg::DAY_MIN;
                  if (month_reg >= ccc_pkg::MONTH_MAX) begin
                    month_next = ccc_pkg::MONTH_MIN;
                    year_next  = (year_reg >= ccc_pkg::YEAR_MAX) ? 14'd0
                                                                 : year_reg + 14'd1;
                  end else begin
                    month_next = month_reg + 4'd1;
                  end
                end else begin
                  day_next = day_reg + 5'd1;
                end
              end else begin
                hours_next = hours_reg + 5'd1;
              end
            end else begin
              minutes_next = minutes_reg + 6'd1;
            end
          end else begin
            seconds_next = seconds_reg + 6'd1;
          end
        end else begin
          tick_count_next = tick_count + TCW'(1);
        end
      end
      ccc_pkg::OP_LOAD_DATE: begin
        year_next = (item.load_year > ccc_pkg::YEAR_MAX) ? ccc_pkg::YEAR_MAX
                                                         : item.load_year;
        if (item.load_month < ccc_pkg::MONTH_MIN) begin
          month_next = ccc_pkg::MONTH_MIN;
        end else if (item.load_month > ccc_pkg::MONTH_MAX) begin
          month_next = ccc_pkg::MONTH_MAX;
        end else begin
          month_next = item.load_month;
        end
        day_next = (item.load_day < ccc_pkg::DAY_MIN) ? ccc_pkg::DAY_MIN : item.load_day;
      end
      ccc_pkg::OP_LOAD_TIME: begin
        hours_next   = (item.load_hours > ccc_pkg::HOURS_MAX) ? ccc_pkg::HOURS_MAX
                                                              : item.load_hours;
        minutes_next = (item.load_minutes > ccc_pkg::MINSEC_MAX) ? ccc_pkg::MINSEC_MAX
                                                                 : item.load_minutes;
        seconds_next = (item.load_seconds > ccc_pkg::MINSEC_MAX) ? ccc_pkg::MINSEC_MAX
                                                                 : item.load_seconds;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.year_now      = year_next;
    result.month_now     = month_next;
    result.day_now       = day_next;
    result.hours_now     = hours_next;
    result.minutes_now   = minutes_next;
    result.seconds_now   = seconds_next;
    result.second_pulse  = sec_p;
    result.new_day_pulse = day_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      seconds_reg <= '0;
      minutes_reg <= '0;
      hours_reg   <= '0;
      day_reg     <= ccc_pkg::DAY_MIN;
      month_reg   <= ccc_pkg::MONTH_MIN;
      year_reg    <= '0;
    end else if (fire) begin
      tick_count  <= tick_count_next;
      seconds_reg <= seconds_next;
      minutes_reg <= minutes_next;
      hours_reg   <= hours_next;
      day_reg     <= day_next;
      month_reg   <= month_next;
      year_reg    <= year_next;
    end
  end

endmodule

// ===== src/ccc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_out_reg: result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module ccc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               d_valid,
  output logic               d_ready,
  input  ccc_pkg::out_item_t d_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ccc_pkg::out_item_t out_data
);

  assign d_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && d_ready) begin
      out_data <= d_data;
    end
  end

endmodule

// ===== src/calendar_clock_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_counter: real-time clock with calendar
// Millisecond-tick driven time and date counter with load operations.
//
//   port group   direction  handshake             payload
//   in           input      in_valid / in_ready   in_data (in_item_t)
//   out          output     out_valid / out_ready out_data (out_item_t)
//   cfg          input      cfg_we                cfg_wdata (fast_mode)
//
// one transaction per cycle sustained while the output is not stalled; a result passes
// from input acceptance through the input register, then the result register
// the rollover logic between the two registers is combinational
// reset: synchronous, clears time to 00:00:00, date to year 0 month 1 day 1
// output stall holds the result register and backs up into the input register
// ----------------------------------------------------------------------------
module calendar_clock_counter #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ccc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ccc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  logic               fast_mode;
  logic               q_valid;
  logic               s2_ready;
  logic               fire;
  ccc_pkg::in_item_t  q_data;
  ccc_pkg::out_item_t core_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_mode <= 1'b0;
    end else if (cfg_we) begin
      fast_mode <= cfg_wdata;
    end
  end

  assign fire = q_valid && s2_ready;

  ccc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_take   (s2_ready),
    .q_data   (q_data)
  );

  ccc_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fast_mode (fast_mode),
    .fire      (fire),
    .item      (q_data),
    .result    (core_result)
  );

  ccc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .d_valid   (q_valid),
    .d_ready   (s2_ready),
    .d_data    (core_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // time fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hours_now <= 5'd23 && out_data.minutes_now <= 6'd59 &&
                   out_data.seconds_now <= 6'd59))
    else $error("time field out of range");

  // date fields stay in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.month_now >= 4'd1 && out_data.month_now <= 4'd12 &&
                   out_data.day_now >= 5'd1 && out_data.year_now <= 14'd9999))
    else $error("date field out of range");

  // a new day only comes with a second step to midnight
  a_new_day: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.new_day_pulse) |->
      (out_data.second_pulse && out_data.hours_now == 5'd0 &&
       out_data.minutes_now == 6'd0 && out_data.seconds_now == 6'd0))
    else $error("new day pulse without midnight rollover");

  // input side never blocks while the result register is free
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free result register");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: calendar_clock_counter verification
// A queue-fed driver sends tick, date-load and time-load transactions while
// a monitor compares every result with an in-bench clock/calendar predictor.
// Directed rollover and clamp cases come first. Randomized phases follow in
// both prescaler modes, with and without random gaps on either side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PRESCALE = 1000;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ccc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ccc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  calendar_clock_counter #(
    .TICKS_PER_SECOND(PRESCALE)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int unsigned days_per_month [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // predicted clock state
  logic [9:0]  cnt_ticks = '0;
  logic [5:0]  cur_sec = '0;
  logic [5:0]  cur_min = '0;
  logic [4:0]  cur_hr = '0;
  logic [4:0]  cur_day = 5'd1;
  logic [3:0]  cur_mon = 4'd1;
  logic [13:0] cur_yr = '0;
  logic        cur_fast = 1'b0;

  ccc_pkg::in_item_t  pending_items_q [$];
  ccc_pkg::out_item_t clock_readings_q [$];

  bit          idle_on = 1'b1;
  int unsigned send_wait;
  int unsigned stall_left;
  int unsigned next_stall;
  int unsigned quiet_cycles;
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned second_pulses;
  int unsigned day_rollovers;
  int unsigned cfg_writes;
  ccc_pkg::out_item_t want;

  function automatic ccc_pkg::out_item_t advance_clock(input ccc_pkg::in_item_t it);
    ccc_pkg::out_item_t r;
    r = '0;
    case (it.op)
      ccc_pkg::OP_TICK: begin
        if (cur_fast || cnt_ticks + 1 >= PRESCALE) begin
          cnt_ticks = '0;
          r.second_pulse = 1'b1;
          if (cur_sec >= ccc_pkg::MINSEC_MAX) begin
            cur_sec = '0;
            if (cur_min >= ccc_pkg::MINSEC_MAX) begin
              cur_min = '0;
              if (cur_hr >= ccc_pkg::HOURS_MAX) begin
                cur_hr = '0;
                r.new_day_pulse = 1'b1;
                if (cur_day >= days_per_month[cur_mon]) begin
                  cur_day = ccc_pkg::DAY_MIN;
                  if (cur_mon >= ccc_pkg::MONTH_MAX) begin
                    cur_mon = ccc_pkg::MONTH_MIN;
                    cur_yr = (cur_yr >= ccc_pkg::YEAR_MAX) ? '0 : cur_yr + 1'b1;
                  end else begin
                    cur_mon = cur_mon + 1'b1;
                  end
                end else begin
                  cur_day = cur_day + 1'b1;
                end
              end else begin
                cur_hr = cur_hr + 1'b1;
              end
            end else begin
              cur_min = cur_min + 1'b1;
            end
          end else begin
            cur_sec = cur_sec + 1'b1;
          end
        end else begin
          cnt_ticks = cnt_ticks + 1'b1;
        end
      end
      ccc_pkg::OP_LOAD_DATE: begin
        cur_yr = (it.load_year > ccc_pkg::YEAR_MAX) ? ccc_pkg::YEAR_MAX : it.load_year;
        cur_mon = (it.load_month < ccc_pkg::MONTH_MIN) ? ccc_pkg::MONTH_MIN :
                  (it.load_month > ccc_pkg::MONTH_MAX) ? ccc_pkg::MONTH_MAX : it.load_month;
        cur_day = (it.load_day < ccc_pkg::DAY_MIN) ? ccc_pkg::DAY_MIN : it.load_day;
      end
      ccc_pkg::OP_LOAD_TIME: begin
        cur_hr = (it.load_hours > ccc_pkg::HOURS_MAX) ? ccc_pkg::HOURS_MAX : it.load_hours;
        cur_min = (it.load_minutes > ccc_pkg::MINSEC_MAX) ? ccc_pkg::MINSEC_MAX
                                                          : it.load_minutes;
        cur_sec = (it.load_seconds > ccc_pkg::MINSEC_MAX) ? ccc_pkg::MINSEC_MAX
                                                          : it.load_seconds;
      end
      default: begin
      end
    endcase
    r.year_now = cur_yr;
    r.month_now = cur_mon;
    r.day_now = cur_day;
    r.hours_now = cur_hr;
    r.minutes_now = cur_min;
    r.seconds_now = cur_sec;
    return r;
  endfunction

  function automatic ccc_pkg::in_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(ccc_pkg::in_item_t)-1:0];
  endfunction

  function automatic ccc_pkg::in_item_t tick_item();
    ccc_pkg::in_item_t it;
    it = noise_item();
    it.op = ccc_pkg::OP_TICK;
    return it;
  endfunction

  function automatic ccc_pkg::in_item_t date_item(input logic [13:0] y,
                                                  input logic [3:0] m,
                                                  input logic [4:0] d);
    ccc_pkg::in_item_t it;
    it = noise_item();
    it.op = ccc_pkg::OP_LOAD_DATE;
    it.load_year = y;
    it.load_month = m;
    it.load_day = d;
    return it;
  endfunction

  function automatic ccc_pkg::in_item_t time_item(input logic [4:0] h,
                                                  input logic [5:0] mi,
                                                  input logic [5:0] s);
    ccc_pkg::in_item_t it;
    it = noise_item();
    it.op = ccc_pkg::OP_LOAD_TIME;
    it.load_hours = h;
    it.load_minutes = mi;
    it.load_seconds = s;
    return it;
  endfunction

  // mostly ticks; loads usually land near a rollover, sometimes raw bits
  function automatic ccc_pkg::in_item_t random_item();
    ccc_pkg::in_item_t it;
    int unsigned pick;
    logic [3:0] m;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      it.op = ccc_pkg::OP_TICK;
    end else if (pick < 84) begin
      it.op = ccc_pkg::OP_LOAD_DATE;
      if ($urandom_range(0, 3) != 0) begin
        m = 4'($urandom_range(1, 12));
        it.load_year = ($urandom_range(0, 3) == 0) ?
                       ccc_pkg::YEAR_MAX - 14'($urandom_range(0, 1)) :
                       14'($urandom_range(0, 9999));
        it.load_month = m;
        it.load_day = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(1, 31)) :
                      5'(days_per_month[m] - $urandom_range(0, 2));
      end
    end else if (pick < 96) begin
      it.op = ccc_pkg::OP_LOAD_TIME;
      if ($urandom_range(0, 3) != 0) begin
        it.load_hours = ($urandom_range(0, 2) != 0) ? ccc_pkg::HOURS_MAX :
                        5'($urandom_range(0, 23));
        it.load_minutes = ($urandom_range(0, 2) != 0) ? ccc_pkg::MINSEC_MAX :
                          6'($urandom_range(0, 59));
        it.load_seconds = 6'($urandom_range(45, 59));
      end
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic set_fast_mode(input logic v);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_fast = v;
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items_q.size() != 0 || in_valid || clock_readings_q.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        clock_readings_q.push_back(advance_clock(in_data));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          in_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_items_q.size() != 0) begin
          in_data <= pending_items_q.pop_front();
          in_valid <= 1'b1;
          send_wait <= idle_on ? $urandom_range(0, 13) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      next_stall = stall_left;
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.second_pulse) second_pulses++;
        if (out_data.new_day_pulse) day_rollovers++;
        if (clock_readings_q.size() == 0) begin
          $error("result transaction with no prediction pending");
          errors++;
        end else begin
          want = clock_readings_q.pop_front();
          check_field("year_now", want.year_now, out_data.year_now);
          check_field("month_now", want.month_now, out_data.month_now);
          check_field("day_now", want.day_now, out_data.day_now);
          check_field("hours_now", want.hours_now, out_data.hours_now);
          check_field("minutes_now", want.minutes_now, out_data.minutes_now);
          check_field("seconds_now", want.seconds_now, out_data.seconds_now);
          check_field("second_pulse", want.second_pulse, out_data.second_pulse);
          check_field("new_day_pulse", want.new_day_pulse, out_data.new_day_pulse);
        end
        next_stall = idle_on ? $urandom_range(0, 13) : 0;
      end
      if (next_stall != 0) begin
        out_ready <= 1'b0;
        stall_left <= next_stall - 1;
      end else begin
        out_ready <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("calendar_clock_counter verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned count;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_fast_mode(1'b1);
    pending_items_q.push_back(tick_item());
    // unused op, all fields high
    pending_items_q.push_back(ccc_pkg::in_item_t'({$bits(ccc_pkg::in_item_t){1'b1}}));
    pending_items_q.push_back(date_item(ccc_pkg::YEAR_MAX, ccc_pkg::MONTH_MAX, 5'd31));
    pending_items_q.push_back(time_item(ccc_pkg::HOURS_MAX, ccc_pkg::MINSEC_MAX,
                                        ccc_pkg::MINSEC_MAX));
    pending_items_q.push_back(tick_item());
    // out-of-range loads saturate
    pending_items_q.push_back(date_item(14'h3fff, 4'hf, 5'h1f));
    pending_items_q.push_back(time_item(5'h1f, 6'h3f, 6'h3f));
    pending_items_q.push_back(tick_item());
    pending_items_q.push_back(date_item('0, '0, '0));
    pending_items_q.push_back(time_item('0, '0, '0));
    // day past month end, then a regular end of february
    pending_items_q.push_back(date_item(14'd5, 4'd2, 5'd31));
    pending_items_q.push_back(time_item(ccc_pkg::HOURS_MAX, ccc_pkg::MINSEC_MAX,
                                        ccc_pkg::MINSEC_MAX));
    pending_items_q.push_back(tick_item());
    pending_items_q.push_back(date_item(14'd7, 4'd2, 5'd28));
    pending_items_q.push_back(time_item(ccc_pkg::HOURS_MAX, ccc_pkg::MINSEC_MAX,
                                        ccc_pkg::MINSEC_MAX));
    pending_items_q.push_back(tick_item());
    wait_drained();

    // a full prescaler period in slow mode, then switch to fast mid-count
    set_fast_mode(1'b0);
    repeat (PRESCALE + 4) pending_items_q.push_back(tick_item());
    wait_drained();
    set_fast_mode(1'b1);
    pending_items_q.push_back(tick_item());
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      idle_on = (p < 2) || (p == 4);
      set_fast_mode(1'(p % 2));
      count = (p < 2) ? 100 : 60;
      for (int i = 0; i < count / 2; i++) pending_items_q.push_back(random_item());
      wait_drained();
      for (int i = count / 2; i < count; i++) pending_items_q.push_back(random_item());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (clock_readings_q.size() != 0) begin
      $error("%0d predicted results never arrived", clock_readings_q.size());
      errors++;
    end
    $display("sent %0d transactions, checked %0d results over %0d mode writes",
             items_sent, results_seen, cfg_writes);
    $display("saw %0d second pulses and %0d day rollovers", second_pulses, day_rollovers);
    if (errors == 0) begin
      $display("calendar_clock_counter verification clean");
    end else begin
      $display("calendar_clock_counter verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ccc_pkg.sv
src/ccc_in_reg.sv
src/ccc_core.sv
src/ccc_out_reg.sv
src/calendar_clock_counter.sv
verif/testbench.sv
